@@ rtl/box_blur_5x5_grayscale_core_assert.svh @@
// Assertion macros for the blur core checker
`ifndef BOX_BLUR_5X5_GRAYSCALE_CORE_ASSERT_SVH
`define BOX_BLUR_5X5_GRAYSCALE_CORE_ASSERT_SVH

// same-cycle implication
`define BB5G_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bb5g assertion failed");

// next-cycle implication
`define BB5G_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bb5g assertion failed");

`endif

@@ rtl/bb5g_pkg.sv @@
`default_nettype none
package bb5g_pkg;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int WINDOW     = 5;
  localparam int HALF       = WINDOW / 2;
  localparam int RING_ROWS  = 3 * HALF + 1;
  localparam int WID_W      = 12;
  localparam int HGT_W      = 13;
  localparam int CFG_W      = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
  localparam int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int RING_W     = $clog2(RING_ROWS);
  localparam int WIN_W      = $clog2(WINDOW);
  localparam int K_W        = $clog2(WINDOW * WINDOW + 1);
  localparam int NPIX_W     = $clog2(WINDOW * WINDOW + 1);
  localparam int SUM_W      = $clog2(WINDOW * WINDOW * 255 + 1);
  localparam int DCNT_W     = $clog2(SUM_W);
  localparam int PIX_W      = 24;
  localparam int DEPTH      = RING_ROWS * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int GSUM_W     = 10;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SH    = 11;
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic {OP_PIXEL = 1'b0, OP_DRAIN = 1'b1} op_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_OUT} state_t;

  typedef struct packed {
    logic idle;
    logic scan;
    logic div;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic scan_done;
    logic div_done;
    logic taken;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/bb5g_pix_if.sv @@
`default_nettype none
interface bb5g_pix_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, op, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, op, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

@@ rtl/bb5g_res_if.sv @@
`default_nettype none
interface bb5g_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray_out;
  logic       frame_last;
  modport source (output valid, gray_out, frame_last, input ready);
  modport sink   (input valid, gray_out, frame_last, output ready);
endinterface
`default_nettype wire

@@ rtl/bb5g_ram.sv @@
`default_nettype none
module bb5g_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/bb5g_datapath.sv @@
`default_nettype none
module bb5g_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bb5g_pkg::cmd_t       cmd,
  output bb5g_pkg::sts_t            sts,
  input  wire logic                 pix_valid,
  input  wire logic                 pix_op,
  input  wire logic [7:0]           red_in,
  input  wire logic [7:0]           green_in,
  input  wire logic [7:0]           blue_in,
  input  wire logic                 res_ready,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_idx,
  input  wire logic [bb5g_pkg::CFG_W-1:0] cfg_data,
  output logic      [7:0]           gray_out,
  output logic                      frame_last
);
  import bb5g_pkg::*;

  logic [WID_W-1:0]  width_reg;
  logic [HGT_W-1:0]  height_reg;
  logic [WID_W-1:0]  wu;
  logic [HGT_W-1:0]  hu;
  logic [COL_W-1:0]  in_col, out_col, cur_col;
  logic [ROW_W-1:0]  in_row, out_row, cur_row;
  logic [RING_W-1:0] in_ring, out_ring, cur_ring;
  logic [CNT_W-1:0]  in_count;
  logic              last;
  logic              acc, complete, emit, is_last, wr;
  logic [K_W-1:0]    k;
  logic [WIN_W-1:0]  wi, wj;
  logic              issue, vld_q, row_ok, col_ok;
  logic [ROW_W:0]    rsum;
  logic [COL_W:0]    csum;
  logic [4:0]        ring_t;
  logic [RING_W-1:0] rd_ring;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [PIX_W-1:0]  rdata;
  logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
  logic [NPIX_W-1:0] npix;
  logic [NPIX_W-1:0] rem_r, rem_g, rem_b;
  logic [NPIX_W:0]   sh_r, sh_g, sh_b;
  logic [DCNT_W-1:0] dcnt;
  logic [GSUM_W-1:0] gsum;
  logic [2*GSUM_W-1:0] prod;

  always_comb begin
    if (width_reg == '0) begin
      wu = WID_W'(1);
    end else if (width_reg > WID_W'(MAX_WIDTH)) begin
      wu = WID_W'(MAX_WIDTH);
    end else begin
      wu = width_reg;
    end
    if (height_reg == '0) begin
      hu = HGT_W'(1);
    end else if (height_reg > HGT_W'(MAX_HEIGHT)) begin
      hu = HGT_W'(MAX_HEIGHT);
    end else begin
      hu = height_reg;
    end
  end

  assign acc      = cmd.idle & pix_valid;
  assign complete = HGT_W'(in_row) >= hu;
  assign wr       = acc & ~complete & (op_t'(pix_op) == OP_PIXEL);
  assign emit     = complete | ((op_t'(pix_op) == OP_PIXEL) &
                    ((in_count + CNT_W'(1)) >=
                     (CNT_W'(wu) * CNT_W'(HALF) + CNT_W'(HALF + 1))));
  assign is_last  = (HGT_W'(out_row) == hu - HGT_W'(1)) &&
                    (WID_W'(out_col) == wu - WID_W'(1));

  assign sts.start     = acc & emit;
  assign sts.scan_done = cmd.scan & (k == K_W'(WINDOW * WINDOW));
  assign sts.div_done  = cmd.div & (dcnt == DCNT_W'(SUM_W - 1));
  assign sts.taken     = res_ready;

  // frame position bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WID_W'(RST_WIDTH);
      height_reg <= HGT_W'(RST_HEIGHT);
      in_col <= '0; in_row <= '0; in_ring <= '0; in_count <= '0;
      out_col <= '0; out_row <= '0; out_ring <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == REG_WIDTH) begin
        width_reg <= cfg_data[WID_W-1:0];
      end else begin
        height_reg <= cfg_data[HGT_W-1:0];
      end
      in_col <= '0; in_row <= '0; in_ring <= '0; in_count <= '0;
      out_col <= '0; out_row <= '0; out_ring <= '0;
    end else if (acc) begin
      if (wr) begin
        in_count <= in_count + CNT_W'(1);
        if (WID_W'(in_col) == wu - WID_W'(1)) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
          in_ring <= (in_ring == RING_W'(RING_ROWS - 1)) ? '0 : in_ring + RING_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (emit) begin
        if (is_last) begin
          in_col <= '0; in_row <= '0; in_ring <= '0; in_count <= '0;
          out_col <= '0; out_row <= '0; out_ring <= '0;
        end else if (WID_W'(out_col) == wu - WID_W'(1)) begin
          out_col <= '0;
          out_row <= out_row + ROW_W'(1);
          out_ring <= (out_ring == RING_W'(RING_ROWS - 1)) ? '0 : out_ring + RING_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  assign waddr = ADDR_W'(in_ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);

  // window scan addressing
  always_comb begin
    issue  = cmd.scan & (k < K_W'(WINDOW * WINDOW));
    rsum   = (ROW_W+1)'(cur_row) + (ROW_W+1)'(wi);
    csum   = (COL_W+1)'(cur_col) + (COL_W+1)'(wj);
    row_ok = (rsum >= (ROW_W+1)'(HALF)) &&
             ((rsum - (ROW_W+1)'(HALF)) < (ROW_W+1)'(hu));
    col_ok = (csum >= (COL_W+1)'(HALF)) &&
             ((csum - (COL_W+1)'(HALF)) < (COL_W+1)'(wu));
    ring_t = 5'(cur_ring) + 5'(wi) + 5'(RING_ROWS - HALF);
    if (ring_t >= 5'(2 * RING_ROWS)) begin
      ring_t = ring_t - 5'(2 * RING_ROWS);
    end else if (ring_t >= 5'(RING_ROWS)) begin
      ring_t = ring_t - 5'(RING_ROWS);
    end
    rd_ring = ring_t[RING_W-1:0];
    raddr   = ADDR_W'(rd_ring) * ADDR_W'(MAX_WIDTH) +
              ADDR_W'(csum[COL_W-1:0] - COL_W'(HALF));
  end

  bb5g_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (waddr),
    .wdata ({red_in, green_in, blue_in}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sh_r = {rem_r, sum_r[SUM_W-1]};
  assign sh_g = {rem_g, sum_g[SUM_W-1]};
  assign sh_b = {rem_b, sum_b[SUM_W-1]};

  // accumulate, then restoring division by neighbour count
  always_ff @(posedge clk) begin
    if (sts.start) begin
      cur_col <= out_col; cur_row <= out_row; cur_ring <= out_ring;
      last <= is_last;
      k <= '0; wi <= '0; wj <= '0; vld_q <= 1'b0;
      sum_r <= '0; sum_g <= '0; sum_b <= '0; npix <= '0;
      rem_r <= '0; rem_g <= '0; rem_b <= '0; dcnt <= '0;
    end else if (cmd.scan) begin
      vld_q <= issue & row_ok & col_ok;
      if (issue) begin
        k <= k + K_W'(1);
        if (wj == WIN_W'(WINDOW - 1)) begin
          wj <= '0;
          wi <= wi + WIN_W'(1);
        end else begin
          wj <= wj + WIN_W'(1);
        end
      end
      if (vld_q) begin
        sum_r <= sum_r + SUM_W'(rdata[23:16]);
        sum_g <= sum_g + SUM_W'(rdata[15:8]);
        sum_b <= sum_b + SUM_W'(rdata[7:0]);
        npix  <= npix + NPIX_W'(1);
      end
    end else if (cmd.div) begin
      dcnt <= dcnt + DCNT_W'(1);
      if (sh_r >= (NPIX_W+1)'(npix)) begin
        rem_r <= NPIX_W'(sh_r - (NPIX_W+1)'(npix));
        sum_r <= {sum_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= sh_r[NPIX_W-1:0];
        sum_r <= {sum_r[SUM_W-2:0], 1'b0};
      end
      if (sh_g >= (NPIX_W+1)'(npix)) begin
        rem_g <= NPIX_W'(sh_g - (NPIX_W+1)'(npix));
        sum_g <= {sum_g[SUM_W-2:0], 1'b1};
      end else begin
        rem_g <= sh_g[NPIX_W-1:0];
        sum_g <= {sum_g[SUM_W-2:0], 1'b0};
      end
      if (sh_b >= (NPIX_W+1)'(npix)) begin
        rem_b <= NPIX_W'(sh_b - (NPIX_W+1)'(npix));
        sum_b <= {sum_b[SUM_W-2:0], 1'b1};
      end else begin
        rem_b <= sh_b[NPIX_W-1:0];
        sum_b <= {sum_b[SUM_W-2:0], 1'b0};
      end
    end
  end

  // quotients are bytes; /3 by reciprocal, exact below 2048
  assign gsum       = GSUM_W'(sum_r[7:0]) + GSUM_W'(sum_g[7:0]) + GSUM_W'(sum_b[7:0]);
  assign prod       = (2*GSUM_W)'(gsum) * (2*GSUM_W)'(DIV3_MUL);
  assign gray_out   = prod[DIV3_SH +: 8];
  assign frame_last = last;
endmodule
`default_nettype wire

@@ rtl/bb5g_ctrl.sv @@
`default_nettype none
module bb5g_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bb5g_pkg::sts_t sts,
  output bb5g_pkg::cmd_t      cmd
);
  import bb5g_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        cmd.out_valid = 1'b1;
        if (sts.taken) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/box_blur_5x5_grayscale_core.sv @@
// Flow: an item with no result leaves the core ready for the next; for one with a result
// the core reads the window from the line store, then runs 13 divide steps, then offers it.
// One request at a time: no new item is accepted until the offered result is taken;
// the pace is set by the single read port of the line store and the bit-serial divider.
// Reset: synchronous, active high; registers return to 640 x 480, frame counters clear.
`default_nettype none
module box_blur_5x5_grayscale_core (
  input  wire logic        clk,
  input  wire logic        rst,
  bb5g_pix_if.sink         pix,
  bb5g_res_if.source       res,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_idx,
  input  wire logic [bb5g_pkg::CFG_W-1:0] cfg_data
);
  import bb5g_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bb5g_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  bb5g_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .pix_valid  (pix.valid),
    .pix_op     (pix.op),
    .red_in     (pix.red_in),
    .green_in   (pix.green_in),
    .blue_in    (pix.blue_in),
    .res_ready  (res.ready),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .gray_out   (res.gray_out),
    .frame_last (res.frame_last)
  );

  assign pix.ready = cmd.idle;
  assign res.valid = cmd.out_valid;
endmodule
`default_nettype wire

@@ rtl/bb5g_checker.sv @@
`default_nettype none
`include "box_blur_5x5_grayscale_core_assert.svh"
module bb5g_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       pix_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [7:0] gray_out,
  input wire logic       frame_last
);
  `BB5G_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(gray_out) && $stable(frame_last))
  `BB5G_ASSERT_NOW(a_one_at_a_time, res_valid, !pix_ready)
  `BB5G_ASSERT_NEXT(a_single_result, res_valid && res_ready, !res_valid && pix_ready)
endmodule

bind box_blur_5x5_grayscale_core bb5g_checker u_bb5g_checker (
  .clk        (clk),
  .rst        (rst),
  .pix_ready  (pix.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .gray_out   (res.gray_out),
  .frame_last (res.frame_last)
);
`default_nettype wire
